// ===== hw/rtl/fhvn_pkg.sv =====
// fhvn_pkg: types, constants and state encodings for the fractal hash value noise block.
// No dependencies; imported by the scramble, lane, merge and top-level files.
`timescale 1ns / 1ps
package fhvn_pkg;

    localparam int VAL_W     = 40;
    localparam int OFF_W     = 48;
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 64 + 2 * FRAC_BITS;

    localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] SM_MUL2  = 64'h94D049BB133111EB;
    localparam logic [63:0] COMP_MIX = 64'h000000009E3779B9;
    localparam logic [63:0] OCT_MIX  = 64'h0000000085EBCA6B;

    localparam logic [1:0] LAST_PHASE = 2'd2;

    localparam logic [2:0] REG_SEED = 3'd0;
    localparam logic [2:0] REG_FREQ = 3'd1;
    localparam logic [2:0] REG_AMP  = 3'd2;
    localparam logic [2:0] REG_OCT  = 3'd3;
    localparam logic [2:0] REG_MULT = 3'd4;

    typedef enum logic [2:0] {SC_IDLE, SC_MUL1, SC_MIX, SC_MUL2, SC_FIN} scr_state_t;
    typedef enum logic [2:0] {LN_IDLE, LN_ISSUE, LN_WAIT, LN_BLEND, LN_ACC} lane_state_t;
    typedef enum logic [2:0] {STEP_SEED, STEP_HN, STEP_SA, STEP_HN1, STEP_SB} step_t;
    typedef enum logic [1:0] {T_IDLE, T_CALC, T_LAUNCH, T_RUN} top_state_t;

    typedef struct packed {
        logic       start;
        logic [4:0] octs;
    } lane_ctl_t;

    typedef struct packed {
        logic busy;
        logic finished;
    } lane_stat_t;

endpackage

// ===== hw/rtl/fhvn_ifs.sv =====
// fhvn_ifs: valid/ready channel interfaces for input and result words.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps
interface fhvn_in_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] sample_time;
    logic signed [39:0] base_x;
    logic signed [39:0] base_y;
    logic signed [39:0] base_z;
    logic signed [39:0] base_w;
    logic [2:0]         component_count;
    modport source (output valid, sample_time, base_x, base_y, base_z, base_w,
                    component_count, input ready);
    modport sink (input valid, sample_time, base_x, base_y, base_z, base_w,
                  component_count, output ready);
endinterface

interface fhvn_out_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] wiggled_x;
    logic signed [39:0] wiggled_y;
    logic signed [39:0] wiggled_z;
    logic signed [39:0] wiggled_w;
    logic [2:0]         valid_components;
    modport source (output valid, wiggled_x, wiggled_y, wiggled_z, wiggled_w,
                    valid_components, input ready);
    modport sink (input valid, wiggled_x, wiggled_y, wiggled_z, wiggled_w,
                  valid_components, output ready);
endinterface

// ===== hw/rtl/fhvn_scramble.sv =====
// fhvn_scramble: multi-cycle splitmix64 finalizer on one shared 32x32 multiplier.
// Depends on fhvn_pkg.
`timescale 1ns / 1ps
module fhvn_scramble
    import fhvn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x_in,
    output logic        done,
    output logic [63:0] y_out
);

    scr_state_t  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] xk;
    logic [63:0] kmul;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] prod;

    always_comb
    begin
        xk   = x_in + SM_GAMMA;
        kmul = (state_reg == SC_MUL2) ? SM_MUL2 : SM_MUL1;
        ma   = (phase_reg == 2'd1) ? a_reg[63:32] : a_reg[31:0];
        mb   = (phase_reg == LAST_PHASE) ? kmul[63:32] : kmul[31:0];
        prod = 64'(ma) * 64'(mb);
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        a_next     = a_reg;
        acc_next   = acc_reg;
        done       = 1'b0;
        unique case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    a_next     = xk ^ (xk >> 30);
                    phase_next = 2'd0;
                    state_next = SC_MUL1;
                end
            end
            SC_MUL1, SC_MUL2:
            begin
                if (phase_reg == 2'd0)
                    acc_next = prod;
                else
                    acc_next = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                if (phase_reg == LAST_PHASE)
                begin
                    phase_next = 2'd0;
                    state_next = (state_reg == SC_MUL1) ? SC_MIX : SC_FIN;
                end
                else
                    phase_next = phase_reg + 2'd1;
            end
            SC_MIX:
            begin
                a_next     = acc_reg ^ (acc_reg >> 27);
                state_next = SC_MUL2;
            end
            SC_FIN:
            begin
                done       = 1'b1;
                state_next = SC_IDLE;
            end
            default: state_next = SC_IDLE;
        endcase
    end

    assign y_out = acc_reg ^ (acc_reg >> 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            phase_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

endmodule

// ===== hw/rtl/fhvn_lane.sv =====
// fhvn_lane: one component lane; steps through the octaves, hashing lattice points,
// blending by smoothstep and accumulating the amplitude-scaled offset. Uses fhvn_scramble.
`timescale 1ns / 1ps
module fhvn_lane
    import fhvn_pkg::*;
#(
    parameter int LANE_IDX = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctl_t               ctl,
    input  logic [63:0]             layer_seed,
    input  logic signed [31:0]      amp_in,
    input  logic [17:0]             mult_in,
    input  logic [POS_W-1:0]        pos_in,
    output lane_stat_t              stat,
    output logic signed [OFF_W-1:0] offset
);

    localparam logic [63:0] LANE_MIX = 64'(LANE_IDX) * COMP_MIX;

    lane_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    logic [4:0]  oct_reg, oct_next;
    logic [4:0]  octs_reg, octs_next;
    logic        fin_reg, fin_next;

    logic [POS_W-1:0]        pos_reg;
    logic [63:0]             kmul_reg;
    logic [63:0]             seed_reg;
    logic [63:0]             hash_reg;
    logic signed [17:0]      a_reg;
    logic signed [17:0]      b_reg;
    logic signed [17:0]      v_reg;
    logic signed [31:0]      amp_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic [15:0]             f2_reg;
    logic [16:0]             s_reg;

    logic               scr_start;
    logic [63:0]        scr_x;
    logic               scr_done;
    logic [63:0]        scr_y;
    logic [15:0]        f;
    logic [31:0]        ff;
    logic [17:0]        t3;
    logic [33:0]        sp;
    logic signed [17:0] sample;
    logic signed [17:0] diff;
    logic signed [35:0] bd;
    logic signed [35:0] bd_sh;
    logic signed [49:0] vm;
    logic signed [49:0] vm_sh;
    logic signed [50:0] am;
    logic signed [50:0] am_sh;
    logic signed [31:0] amp_sat;
    logic [63:0]        n_cur;

    fhvn_scramble u_scr (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scr_start),
        .x_in  (scr_x),
        .done  (scr_done),
        .y_out (scr_y)
    );

    always_comb
    begin
        n_cur  = pos_reg[POS_W-1:2*FRAC_BITS];
        f      = pos_reg[2*FRAC_BITS-1 -: FRAC_BITS];
        ff     = 32'(f) * 32'(f);
        t3     = 18'(3 << FRAC_BITS) - {1'b0, f, 1'b0};
        sp     = 34'(f2_reg) * 34'(t3);
        sample = $signed({2'b00, scr_y[63:48]}) - 18'sd32768;
        diff   = b_reg - a_reg;
        bd     = diff * $signed({1'b0, s_reg});
        bd_sh  = bd >>> FRAC_BITS;
        vm     = v_reg * amp_reg;
        vm_sh  = vm >>> 15;
        am     = amp_reg * $signed({1'b0, mult_in});
        am_sh  = am >>> 16;
        if (am_sh[50] && !(&am_sh[49:31]))
            amp_sat = 32'sh80000000;
        else if (!am_sh[50] && (|am_sh[49:31]))
            amp_sat = 32'sh7FFFFFFF;
        else
            amp_sat = am_sh[31:0];
    end

    always_comb
    begin
        case (step_reg)
            STEP_SEED: scr_x = layer_seed ^ LANE_MIX ^ kmul_reg;
            STEP_HN:   scr_x = n_cur;
            STEP_HN1:  scr_x = n_cur + 64'd1;
            default:   scr_x = seed_reg ^ hash_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        oct_next   = oct_reg;
        octs_next  = octs_reg;
        fin_next   = fin_reg;
        scr_start  = 1'b0;
        unique case (state_reg)
            LN_IDLE:
            begin
                if (ctl.start)
                begin
                    octs_next  = ctl.octs;
                    oct_next   = 5'd0;
                    fin_next   = 1'b0;
                    step_next  = STEP_SEED;
                    state_next = LN_ISSUE;
                end
            end
            LN_ISSUE:
            begin
                scr_start  = 1'b1;
                state_next = LN_WAIT;
            end
            LN_WAIT:
            begin
                if (scr_done)
                begin
                    state_next = LN_ISSUE;
                    unique case (step_reg)
                        STEP_SEED: step_next = STEP_HN;
                        STEP_HN:   step_next = STEP_SA;
                        STEP_SA:   step_next = STEP_HN1;
                        STEP_HN1:  step_next = STEP_SB;
                        default:   state_next = LN_BLEND;
                    endcase
                end
            end
            LN_BLEND: state_next = LN_ACC;
            LN_ACC:
            begin
                if (5'(oct_reg + 5'd1) == octs_reg)
                begin
                    fin_next   = 1'b1;
                    state_next = LN_IDLE;
                end
                else
                begin
                    oct_next   = 5'(oct_reg + 5'd1);
                    step_next  = STEP_SEED;
                    state_next = LN_ISSUE;
                end
            end
            default: state_next = LN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
            step_reg  <= STEP_SEED;
            oct_reg   <= 5'd0;
            octs_reg  <= 5'd1;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            oct_reg   <= oct_next;
            octs_reg  <= octs_next;
            fin_reg   <= fin_next;
        end
    end

    // smoothstep pipeline runs freely; position holds for a whole octave
    always_ff @(posedge clk)
    begin
        f2_reg <= ff[31:16];
        s_reg  <= sp[32:16];
        case (state_reg)
            LN_IDLE:
            begin
                if (ctl.start)
                begin
                    pos_reg  <= pos_in;
                    kmul_reg <= 64'd0;
                    amp_reg  <= amp_in;
                    off_reg  <= '0;
                end
            end
            LN_WAIT:
            begin
                if (scr_done)
                begin
                    case (step_reg)
                        STEP_SEED: seed_reg <= scr_y;
                        STEP_SA:   a_reg    <= sample;
                        STEP_SB:   b_reg    <= sample;
                        default:   hash_reg <= scr_y;
                    endcase
                end
            end
            LN_BLEND: v_reg <= a_reg + bd_sh[17:0];
            LN_ACC:
            begin
                off_reg  <= off_reg + vm_sh[OFF_W-1:0];
                amp_reg  <= amp_sat;
                pos_reg  <= pos_reg << 1;
                kmul_reg <= kmul_reg + OCT_MIX;
            end
            default: ;
        endcase
    end

    assign stat.busy     = (state_reg != LN_IDLE);
    assign stat.finished = fin_reg;
    assign offset        = off_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        scr_done |-> (state_reg == LN_WAIT))
        else $error("hash result outside wait state");
    a_oct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != LN_IDLE) |-> (oct_reg < octs_reg))
        else $error("octave counter past octave count");
    a_fin_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(fin_reg) |-> $past(state_reg == LN_ACC))
        else $error("lane finished without last accumulate");

endmodule

// ===== hw/rtl/fhvn_merge.sv =====
// fhvn_merge: combines lane offsets with the base components, saturating to 40 bits
// and zeroing components past the count. Depends on fhvn_pkg.
`timescale 1ns / 1ps
module fhvn_merge
    import fhvn_pkg::*;
#(
    parameter int N_LANES = 4
)
(
    input  logic signed [VAL_W-1:0] base [4],
    input  logic signed [OFF_W-1:0] off [N_LANES],
    input  logic [2:0]              comps,
    output logic signed [VAL_W-1:0] wig [4]
);

    for (genvar c = 0; c < 4; c++)
    begin : g_comp
        if (c < N_LANES)
        begin : g_used
            logic signed [OFF_W:0] sum;
            always_comb
            begin
                sum = {{(OFF_W + 1 - VAL_W){base[c][VAL_W-1]}}, base[c]}
                    + {off[c][OFF_W-1], off[c]};
                if (3'(c) >= comps)
                    wig[c] = '0;
                else if (sum[OFF_W] && !(&sum[OFF_W-1:VAL_W-1]))
                    wig[c] = {1'b1, {(VAL_W - 1){1'b0}}};
                else if (!sum[OFF_W] && (|sum[OFF_W-1:VAL_W-1]))
                    wig[c] = {1'b0, {(VAL_W - 1){1'b1}}};
                else
                    wig[c] = sum[VAL_W-1:0];
            end
        end
        else
        begin : g_unused
            assign wig[c] = '0;
        end
    end

endmodule

// ===== hw/rtl/fractal_hash_value_noise.sv =====
// fractal_hash_value_noise: top level; APB register file, input capture, lane launch,
// merge and output register. Depends on fhvn_pkg, fhvn_ifs, fhvn_lane, fhvn_merge.
//
// Usage: program layer_seed, frequency, amplitude, octave_count and amplitude_multiplier
// over APB (64-bit data, register i at byte 8*i) while idle. Send a word on in_ch; one
// result word comes back on out_ch with each of the first component_count components
// offset by fractal value noise, the rest zero.
// One lane per component runs all octaves in lockstep. Each octave runs five splitmix64
// hashes in turn through the lane's shared 32x32 multiplier, then a blend state and an
// accumulate state. Items are processed one at a time: no new word is accepted until
// the previous item's result has been loaded into the output register.
// A new word is accepted while a finished result waits in the output register; a
// stalled receiver holds the result and stops the next item only at its merge.
// Reset clears the registers to their defaults and empties the block.
`timescale 1ns / 1ps
module fractal_hash_value_noise
    import fhvn_pkg::*;
#(
    parameter int MAX_OCTAVES    = 16,
    parameter int MAX_COMPONENTS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    fhvn_in_if.sink     in_ch,
    fhvn_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    top_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    logic [63:0]        seed_cfg_reg;
    logic [23:0]        freq_cfg_reg;
    logic signed [31:0] amp_cfg_reg;
    logic [4:0]         oct_cfg_reg;
    logic [17:0]        mult_cfg_reg;

    logic signed [VAL_W-1:0] t_reg;
    logic signed [VAL_W-1:0] base_reg [4];
    logic [2:0]              comps_reg;
    logic [POS_W-1:0]        pos_reg;
    logic signed [VAL_W-1:0] wig_reg [4];
    logic [2:0]              vc_reg;

    logic                    wr_en;
    logic [2:0]              reg_idx;
    logic [4:0]              octs;
    logic [2:0]              comps_in;
    logic signed [64:0]      prod;
    logic                    load;
    logic                    all_fin;
    logic                    any_busy;
    lane_ctl_t               ctl;
    lane_stat_t              stat [MAX_COMPONENTS];
    logic [MAX_COMPONENTS-1:0] fin_vec;
    logic [MAX_COMPONENTS-1:0] busy_vec;
    logic signed [OFF_W-1:0] off [MAX_COMPONENTS];
    logic signed [VAL_W-1:0] wig [4];

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_comb
    begin
        unique case (reg_idx)
            REG_SEED: prdata = seed_cfg_reg;
            REG_FREQ: prdata = {40'd0, freq_cfg_reg};
            REG_AMP:  prdata = {32'd0, amp_cfg_reg};
            REG_OCT:  prdata = {59'd0, oct_cfg_reg};
            REG_MULT: prdata = {46'd0, mult_cfg_reg};
            default:  prdata = 64'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_cfg_reg <= 64'd0;
            freq_cfg_reg <= 24'd0;
            amp_cfg_reg  <= 32'sd0;
            oct_cfg_reg  <= 5'd1;
            mult_cfg_reg <= 18'd32768;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SEED: seed_cfg_reg <= pwdata;
                REG_FREQ: freq_cfg_reg <= pwdata[23:0];
                REG_AMP:  amp_cfg_reg  <= pwdata[31:0];
                REG_OCT:  oct_cfg_reg  <= pwdata[4:0];
                REG_MULT: mult_cfg_reg <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (oct_cfg_reg == 5'd0)
            octs = 5'd1;
        else if (oct_cfg_reg > 5'(MAX_OCTAVES))
            octs = 5'(MAX_OCTAVES);
        else
            octs = oct_cfg_reg;
        if (in_ch.component_count == 3'd0)
            comps_in = 3'd1;
        else if (in_ch.component_count > 3'(MAX_COMPONENTS))
            comps_in = 3'(MAX_COMPONENTS);
        else
            comps_in = in_ch.component_count;
        prod = t_reg * $signed({1'b0, freq_cfg_reg});
    end

    for (genvar l = 0; l < MAX_COMPONENTS; l++)
    begin : g_lane
        fhvn_lane #(.LANE_IDX(l)) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .layer_seed (seed_cfg_reg),
            .amp_in     (amp_cfg_reg),
            .mult_in    (mult_cfg_reg),
            .pos_in     (pos_reg),
            .stat       (stat[l]),
            .offset     (off[l])
        );
        assign fin_vec[l]  = stat[l].finished;
        assign busy_vec[l] = stat[l].busy;
    end

    fhvn_merge #(.N_LANES(MAX_COMPONENTS)) u_merge (
        .base  (base_reg),
        .off   (off),
        .comps (comps_reg),
        .wig   (wig)
    );

    assign all_fin  = &fin_vec;
    assign any_busy = |busy_vec;

    always_comb
    begin
        state_next   = state_reg;
        in_ch.ready  = 1'b0;
        ctl.start    = 1'b0;
        ctl.octs     = octs;
        load         = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                    state_next = T_CALC;
            end
            T_CALC: state_next = T_LAUNCH;
            T_LAUNCH:
            begin
                ctl.start  = 1'b1;
                state_next = T_RUN;
            end
            T_RUN:
            begin
                if (all_fin && !any_busy && (!out_valid_reg || out_ch.ready))
                begin
                    load       = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
        if (load)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            t_reg       <= in_ch.sample_time;
            base_reg[0] <= in_ch.base_x;
            base_reg[1] <= in_ch.base_y;
            base_reg[2] <= in_ch.base_z;
            base_reg[3] <= in_ch.base_w;
            comps_reg   <= comps_in;
        end
        if (state_reg == T_CALC)
            pos_reg <= {{32{prod[63]}}, prod[63:0]};
        if (load)
        begin
            wig_reg <= wig;
            vc_reg  <= comps_reg;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.wiggled_x        = wig_reg[0];
    assign out_ch.wiggled_y        = wig_reg[1];
    assign out_ch.wiggled_z        = wig_reg[2];
    assign out_ch.wiggled_w        = wig_reg[3];
    assign out_ch.valid_components = vc_reg;

    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(fin_vec) == 0) || ($countones(fin_vec) == MAX_COMPONENTS))
        else $error("lanes out of step");

endmodule
